### rtl/hacr_pkg.sv
// Shared types and constants for the hub-aware counter replacement block.
// No dependencies; imported by the top level, front end, queue and back end.
package hacr_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;
    localparam int CNT_W       = 5;

    localparam logic [2:0] MODE_TICK  = 3'd0;
    localparam logic [2:0] MODE_HIT   = 3'd1;
    localparam logic [2:0] MODE_FILL  = 3'd2;
    localparam logic [2:0] MODE_INVAL = 3'd3;

    localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_HIT,
        OP_FILL,
        OP_INVAL,
        OP_QUERY
    } op_t;

    typedef enum logic [1:0] {
        CFG_RESERVED = 2'd0,
        CFG_LRU_STEP = 2'd1,
        CFG_MRU_STEP = 2'd2,
        CFG_INVALID  = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } back_state_t;

    typedef struct packed {
        op_t         op;
        logic [3:0]  way;
        logic        hub;
        logic        inr;
        logic [15:0] l1_hit_count;
        logic        from_llc_before;
        logic [63:0] count_threshold;
    } item_t;

    typedef struct packed {
        logic        lru_we;
        logic        mru_we;
        logic [63:0] data;
    } step_wr_t;

endpackage

### rtl/hub_aware_counter_replacement_top.sv
// Top level of the hub-aware counter replacement block for one cache set.
// Depends on hacr_pkg, hacr_front, hacr_queue, hacr_back.
// An item passes the back-end states idle, read, scan, drain and done, with a
// multiply state added on a fill after LLC service (split 16x64 multiply). The
// back end takes no new item until its result is loaded; the scan reads the counter
// RAM one way per cycle. Reset: counters read zero, flags set, steps zero, no sweep.
module hub_aware_counter_replacement_top #(
    parameter int TOTAL_WAYS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  mode,
    input  logic [3:0]  way,
    input  logic [31:0] node_degree,
    input  logic [31:0] average_degree,
    input  logic [15:0] l1_hit_count,
    input  logic        from_llc_before,
    input  logic [63:0] count_threshold,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  victim_way,
    output logic [3:0]  reserved_victim_way,
    output logic        reserved_victim_valid,
    output logic [63:0] way_counter_value,
    output logic [4:0]  count_above,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import hacr_pkg::*;

    logic        q_full, push, pop, q_valid, cfg_we;
    item_t       push_item, head_item;
    step_wr_t    step_wr;
    logic [3:0]  reserved_reg, reserved_next;
    logic [63:0] invalid_reg, invalid_next;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_comb
    begin
        reserved_next  = reserved_reg;
        invalid_next   = invalid_reg;
        step_wr.lru_we = 1'b0;
        step_wr.mru_we = 1'b0;
        step_wr.data   = cfg_data;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_RESERVED: reserved_next  = cfg_data[3:0];
                CFG_LRU_STEP: step_wr.lru_we = 1'b1;
                CFG_MRU_STEP: step_wr.mru_we = 1'b1;
                CFG_INVALID:  invalid_next   = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reserved_reg <= '0;
            invalid_reg  <= '1;
        end
        else
        begin
            reserved_reg <= reserved_next;
            invalid_reg  <= invalid_next;
        end
    end

    hacr_front #(
        .TOTAL_WAYS(TOTAL_WAYS)
    ) u_front (
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .mode            (mode),
        .way             (way),
        .node_degree     (node_degree),
        .average_degree  (average_degree),
        .l1_hit_count    (l1_hit_count),
        .from_llc_before (from_llc_before),
        .count_threshold (count_threshold),
        .q_full          (q_full),
        .push            (push),
        .push_item       (push_item)
    );

    hacr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .head_item (head_item)
    );

    hacr_back #(
        .TOTAL_WAYS(TOTAL_WAYS)
    ) u_back (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .q_valid               (q_valid),
        .head_item             (head_item),
        .pop                   (pop),
        .reserved_way_count    (reserved_reg),
        .invalid_counter_value (invalid_reg),
        .step_wr               (step_wr),
        .out_valid             (out_valid),
        .out_ready             (out_ready),
        .victim_way            (victim_way),
        .reserved_victim_way   (reserved_victim_way),
        .reserved_victim_valid (reserved_victim_valid),
        .way_counter_value     (way_counter_value),
        .count_above           (count_above)
    );

endmodule

### rtl/hacr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hacr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/hacr_front.sv
// Front end: accepts input items, runs the hub test and decodes the mode.
// Depends on hacr_pkg; feeds hacr_queue.
module hacr_front #(
    parameter int TOTAL_WAYS = 16
) (
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [2:0]     mode,
    input  logic [3:0]     way,
    input  logic [31:0]    node_degree,
    input  logic [31:0]    average_degree,
    input  logic [15:0]    l1_hit_count,
    input  logic           from_llc_before,
    input  logic [63:0]    count_threshold,
    input  logic           q_full,
    output logic           push,
    output hacr_pkg::item_t push_item
);
    import hacr_pkg::*;

    logic inr;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;
    assign inr      = int'(way) < TOTAL_WAYS;

    always_comb
    begin
        push_item.way             = way;
        push_item.hub             = node_degree > average_degree;
        push_item.inr             = inr;
        push_item.l1_hit_count    = l1_hit_count;
        push_item.from_llc_before = from_llc_before;
        push_item.count_threshold = count_threshold;
        unique case (mode)
            MODE_TICK:  push_item.op = OP_TICK;
            MODE_HIT:   push_item.op = inr ? OP_HIT : OP_QUERY;
            MODE_FILL:  push_item.op = inr ? OP_FILL : OP_QUERY;
            MODE_INVAL: push_item.op = inr ? OP_INVAL : OP_QUERY;
            default:    push_item.op = OP_QUERY;
        endcase
    end

endmodule

### rtl/hacr_queue.sv
// Short item queue between the front end and the back end.
// Depends on hacr_pkg.
module hacr_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  hacr_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            q_valid,
    output hacr_pkg::item_t head_item
);
    import hacr_pkg::*;

    item_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push, do_pop;

    assign full      = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign q_valid   = count_reg != '0;
    assign head_item = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/hacr_back.sv
// Back end: updates way counters, flags and step counters, then scans all
// ways for victims and threshold count. Depends on hacr_pkg and hacr_ram.
module hacr_back #(
    parameter int TOTAL_WAYS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  hacr_pkg::item_t    head_item,
    output logic               pop,
    input  logic [3:0]         reserved_way_count,
    input  logic [63:0]        invalid_counter_value,
    input  hacr_pkg::step_wr_t step_wr,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [3:0]         victim_way,
    output logic [3:0]         reserved_victim_way,
    output logic               reserved_victim_valid,
    output logic [63:0]        way_counter_value,
    output logic [4:0]         count_above
);
    import hacr_pkg::*;

    localparam int WIDX = $clog2(TOTAL_WAYS);
    localparam int NWW  = $clog2(TOTAL_WAYS + 1);

    back_state_t      state_reg, state_next;
    item_t            item_reg, item_next;
    logic [WIDX-1:0]  idx_reg, idx_next;
    logic [NWW-1:0]   nw_reg, nw_next;
    logic [63:0]      res_reg, res_next;
    logic [47:0]      plo_reg, plo_next;
    logic [47:0]      phi_reg, phi_next;
    logic [63:0]      lru_step_reg, lru_step_next;
    logic [63:0]      mru_step_reg, mru_step_next;
    logic [TOTAL_WAYS-1:0] valid_reg, valid_next;
    logic [TOTAL_WAYS-1:0] lowpri_reg, lowpri_next;
    logic             cmp_valid_reg, cmp_go;
    logic [WIDX-1:0]  cmp_idx_reg;
    logic [63:0]      nmin_reg, nmin_next;
    logic [WIDX-1:0]  nidx_reg, nidx_next;
    logic [63:0]      rmin_reg, rmin_next;
    logic [WIDX-1:0]  ridx_reg, ridx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next, out_load;
    logic [3:0]       victim_reg, rvictim_reg;
    logic             rvalid_reg;
    logic [63:0]      wcv_reg;
    logic [4:0]       count_reg;

    logic             ram_we;
    logic [WIDX-1:0]  ram_waddr, ram_raddr, way_addr;
    logic [63:0]      ram_wdata, ram_rdata;
    logic [NWW-1:0]   rsat;
    logic [63:0]      cur, fill_step, hit_sum, mul_sum, scan_val;
    logic             flag_new, gt;

    hacr_ram #(
        .WIDTH(64),
        .DEPTH(TOTAL_WAYS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign way_addr  = WIDX'(item_reg.way);
    assign rsat      = (int'(reserved_way_count) > TOTAL_WAYS - 1) ?
                       NWW'(TOTAL_WAYS - 1) : NWW'(reserved_way_count);
    assign cur       = valid_reg[way_addr] ? ram_rdata : 64'd0;
    assign flag_new  = item_reg.hub ? 1'b0 : lowpri_reg[way_addr];
    assign hit_sum   = cur + (flag_new ? lru_step_reg : mru_step_reg);
    assign fill_step = item_reg.hub ? mru_step_reg : lru_step_reg;
    assign mul_sum   = 64'(plo_reg) + {phi_reg[31:0], 32'd0};
    assign scan_val  = valid_reg[cmp_idx_reg] ? ram_rdata : 64'd0;
    assign gt        = scan_val > item_reg.count_threshold;

    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        idx_next      = idx_reg;
        nw_next       = nw_reg;
        res_next      = res_reg;
        plo_next      = plo_reg;
        phi_next      = phi_reg;
        lru_step_next = lru_step_reg;
        mru_step_next = mru_step_reg;
        valid_next    = valid_reg;
        lowpri_next   = lowpri_reg;
        pop           = 1'b0;
        cmp_go        = 1'b0;
        out_load      = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = way_addr;
        ram_wdata     = 64'd0;
        ram_raddr     = idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                ram_raddr = WIDX'(head_item.way);
                if (q_valid)
                begin
                    pop        = 1'b1;
                    item_next  = head_item;
                    nw_next    = NWW'(TOTAL_WAYS) - rsat;
                    idx_next   = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_SCAN;
                res_next   = item_reg.inr ? cur : 64'd0;
                case (item_reg.op)
                    OP_TICK:
                    begin
                        lru_step_next = lru_step_reg + 64'd1;
                        mru_step_next = mru_step_reg + 64'(nw_reg);
                    end
                    OP_HIT:
                    begin
                        lowpri_next[way_addr] = flag_new;
                        valid_next[way_addr]  = 1'b1;
                        ram_we                = 1'b1;
                        ram_wdata             = hit_sum;
                        res_next              = hit_sum;
                    end
                    OP_FILL:
                    begin
                        lowpri_next[way_addr] = !item_reg.hub;
                        if (item_reg.from_llc_before)
                        begin
                            plo_next   = 48'(item_reg.l1_hit_count) * 48'(fill_step[31:0]);
                            phi_next   = 48'(item_reg.l1_hit_count) * 48'(fill_step[63:32]);
                            state_next = ST_MUL;
                        end
                        else
                        begin
                            valid_next[way_addr] = 1'b1;
                            ram_we               = 1'b1;
                            ram_wdata            = fill_step;
                            res_next             = fill_step;
                        end
                    end
                    OP_INVAL:
                    begin
                        lowpri_next[way_addr] = 1'b1;
                        valid_next[way_addr]  = 1'b1;
                        ram_we                = 1'b1;
                        ram_wdata             = invalid_counter_value;
                        res_next              = invalid_counter_value;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_MUL:
            begin
                valid_next[way_addr] = 1'b1;
                ram_we               = 1'b1;
                ram_wdata            = mul_sum;
                res_next             = mul_sum;
                state_next           = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmp_go = 1'b1;
                if (idx_reg == WIDX'(TOTAL_WAYS - 1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (step_wr.lru_we)
        begin
            lru_step_next = step_wr.data;
        end
        if (step_wr.mru_we)
        begin
            mru_step_next = step_wr.data;
        end

        out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_comb
    begin
        nmin_next = nmin_reg;
        nidx_next = nidx_reg;
        rmin_next = rmin_reg;
        ridx_next = ridx_reg;
        cnt_next  = cnt_reg;
        if (cmp_valid_reg)
        begin
            if (NWW'(cmp_idx_reg) < nw_reg)
            begin
                if (cmp_idx_reg == '0 || scan_val < nmin_reg)
                begin
                    nmin_next = scan_val;
                    nidx_next = cmp_idx_reg;
                end
            end
            else if (NWW'(cmp_idx_reg) == nw_reg || scan_val < rmin_reg)
            begin
                rmin_next = scan_val;
                ridx_next = cmp_idx_reg;
            end
            if (cmp_idx_reg == '0)
            begin
                cnt_next = CNT_W'(gt);
            end
            else if (gt && cnt_reg != CNT_MAX)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lru_step_reg  <= '0;
            mru_step_reg  <= '0;
            valid_reg     <= '0;
            lowpri_reg    <= '1;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lru_step_reg  <= lru_step_next;
            mru_step_reg  <= mru_step_next;
            valid_reg     <= valid_next;
            lowpri_reg    <= lowpri_next;
            cmp_valid_reg <= cmp_go;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        idx_reg     <= idx_next;
        nw_reg      <= nw_next;
        res_reg     <= res_next;
        plo_reg     <= plo_next;
        phi_reg     <= phi_next;
        cmp_idx_reg <= idx_reg;
        nmin_reg    <= nmin_next;
        nidx_reg    <= nidx_next;
        rmin_reg    <= rmin_next;
        ridx_reg    <= ridx_next;
        cnt_reg     <= cnt_next;
        if (out_load)
        begin
            victim_reg  <= 4'(nidx_reg);
            rvalid_reg  <= nw_reg != NWW'(TOTAL_WAYS);
            rvictim_reg <= (nw_reg != NWW'(TOTAL_WAYS)) ? 4'(ridx_reg) : 4'd0;
            wcv_reg     <= res_reg;
            count_reg   <= cnt_reg;
        end
    end

    assign out_valid             = out_valid_reg;
    assign victim_way            = victim_reg;
    assign reserved_victim_way   = rvictim_reg;
    assign reserved_victim_valid = rvalid_reg;
    assign way_counter_value     = wcv_reg;
    assign count_above           = count_reg;

endmodule

### rtl/hacr_checker.sv
// Port-level checks for the hub-aware counter replacement top level.
// Depends on hub_aware_counter_replacement_top; attached by bind below.
module hacr_checker #(
    parameter int TOTAL_WAYS = 16
) (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  victim_way,
    input logic [3:0]  reserved_victim_way,
    input logic        reserved_victim_valid,
    input logic [63:0] way_counter_value,
    input logic [4:0]  count_above
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(victim_way) &&
        $stable(way_counter_value) && $stable(count_above))
        else $error("result item changed while stalled");

    a_empty_reserved: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !reserved_victim_valid |-> reserved_victim_way == 4'd0)
        else $error("reserved victim reported for an empty region");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> int'(count_above) <= TOTAL_WAYS)
        else $error("count above exceeds way count");

    a_region_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reserved_victim_valid && TOTAL_WAYS <= 16 |->
        victim_way < reserved_victim_way)
        else $error("normal victim not below reserved victim");

endmodule

bind hub_aware_counter_replacement_top hacr_checker #(
    .TOTAL_WAYS(TOTAL_WAYS)
) u_hacr_checker (.*);
